[rtl/mbtf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbtf_pkg
// Shared constants, codes, command and status types of the mipmap filter.
// ----------------------------------------------------------------------------
package mbtf_pkg;

	localparam int MAX_DIM     = 64;
	localparam int STORE_DEPTH = 8192;
	localparam int MAX_LEVELS  = 7;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int DIM_W       = $clog2(MAX_DIM) + 1;
	localparam int IDX_W       = $clog2(MAX_DIM);
	localparam int LVL_W       = $clog2(MAX_LEVELS + 1);

	typedef enum logic [2:0] {
		REG_FILTER_MODE   = 3'd0,
		REG_WRAP_U        = 3'd1,
		REG_WRAP_V        = 3'd2,
		REG_BASE_WIDTH    = 3'd3,
		REG_BASE_HEIGHT   = 3'd4,
		REG_LEVEL_COUNT   = 3'd5,
		REG_CHANNEL_COUNT = 3'd6,
		REG_UNUSED        = 3'd7
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_PREP,
		S_LOG,
		S_DECIDE,
		S_OFS,
		S_POS,
		S_WRAP,
		S_TAP,
		S_DRAIN,
		S_PEND,
		S_FIN
	} state_t;

	typedef struct packed {
		logic       wr_en;
		logic       start;
		logic       log_step;
		logic       lvl_zero;
		logic       lvl_il;
		logic       lvl_inc;
		logic       ofs_clear;
		logic       ofs_step;
		logic       pos_calc;
		logic       wrap_calc;
		logic       acc_clear;
		logic       rd_en;
		logic [1:0] tap;
		logic       save_r0;
		logic       out_load;
		logic       blend;
	} cmd_t;

	typedef struct packed {
		logic linear;
		logic multi;
		logic fp_nz;
		logic blend_ok;
		logic ofs_done;
		logic out_busy;
	} status_t;

	function automatic logic [DIM_W-1:0] lvl_dim(input logic [DIM_W-1:0] base,
		input logic [LVL_W-1:0] l);
		logic [DIM_W-1:0] d;
		d = base >> l;
		return (d == '0) ? DIM_W'(1) : d;
	endfunction

endpackage
`default_nettype wire

[rtl/mipmap_bilinear_texture_filter_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mipmap_bilinear_texture_filter_top
// Mipmapped RGBA8 texture filter with an on-chip texel store.
// ----------------------------------------------------------------------------
// A write word stores one texel. A sample word runs in nearest mode, as a
// bilinear sample at level 0 (also when a level is computed and falls
// below zero) or as a blend of two levels: serial log2 squaring, a level
// offset sweep over each lower level, and four texel reads per level
// through the single store port. The finished colour waits in an output
// register; a new word is taken as soon as the sequencer returns to idle.
module mipmap_bilinear_texture_filter_top import mbtf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic               func,
	input  wire logic [ADDR_W-1:0]  texel_address,
	input  wire logic [31:0]        texel_value,
	input  wire logic signed [23:0] u_coord,
	input  wire logic signed [23:0] v_coord,
	input  wire logic [15:0]        footprint,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             channel_r,
	output logic [15:0]             channel_g,
	output logic [15:0]             channel_b,
	output logic [15:0]             channel_a
);

	cmd_t    cmd;
	status_t st;

	mbtf_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.func    (func),
		.in_ready(in_ready),
		.st      (st),
		.cmd     (cmd)
	);

	mbtf_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.texel_address(texel_address),
		.texel_value  (texel_value),
		.u_coord      (u_coord),
		.v_coord      (v_coord),
		.footprint    (footprint),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.channel_r    (channel_r),
		.channel_g    (channel_g),
		.channel_b    (channel_b),
		.channel_a    (channel_a)
	);

	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !cmd.wr_en)
		else $error("store read and write in the same cycle");

	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !(out_valid && !out_ready))
		else $error("result loaded over a waiting word");

	a_valid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(cmd.out_load))
		else $error("result valid without a load");

	a_ready_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.rd_en |-> !in_ready)
		else $error("input taken while taps are read");

endmodule
`default_nettype wire

[rtl/mbtf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbtf_ram
// Generic single-port RAM, one access per cycle, registered read.
// ----------------------------------------------------------------------------
module mbtf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8192
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] addr,
	input  wire logic [WIDTH-1:0]         wdata,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule
`default_nettype wire

[rtl/mbtf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbtf_ctrl
// Sequencer: log2 iterations, level offset sweep, tap reads, result hand-off.
// ----------------------------------------------------------------------------
module mbtf_ctrl import mbtf_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	input  wire logic    func,
	output logic         in_ready,
	input  wire status_t st,
	output cmd_t         cmd
);

	state_t     state_q, state_d;
	logic [2:0] cnt_q, cnt_d;
	logic       pass_q, pass_d;
	logic       blend_q, blend_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pass_q  <= 1'b0;
			blend_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
			pass_q  <= pass_d;
			blend_q <= blend_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cnt_d     = cnt_q;
		pass_d    = pass_q;
		blend_d   = blend_q;
		cmd       = '0;
		cmd.tap   = cnt_q[1:0];
		cmd.blend = blend_q;
		in_ready  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!func) begin
						cmd.wr_en = 1'b1;
					end else begin
						cmd.start = 1'b1;
						state_d   = S_PREP;
					end
				end
			end
			S_PREP: begin
				pass_d = 1'b0;
				cnt_d  = '0;
				if (st.linear && st.multi && st.fp_nz) begin
					state_d = S_LOG;
				end else begin
					cmd.lvl_zero  = 1'b1;
					cmd.ofs_clear = 1'b1;
					blend_d       = 1'b0;
					state_d       = S_OFS;
				end
			end
			S_LOG: begin
				cmd.log_step = 1'b1;
				cnt_d        = cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					state_d = S_DECIDE;
				end
			end
			S_DECIDE: begin
				cmd.ofs_clear = 1'b1;
				if (st.blend_ok) begin
					cmd.lvl_il = 1'b1;
					blend_d    = 1'b1;
				end else begin
					cmd.lvl_zero = 1'b1;
					blend_d      = 1'b0;
				end
				state_d = S_OFS;
			end
			S_OFS: begin
				if (st.ofs_done) begin
					state_d = S_POS;
				end else begin
					cmd.ofs_step = 1'b1;
				end
			end
			S_POS: begin
				cmd.pos_calc = 1'b1;
				state_d      = S_WRAP;
			end
			S_WRAP: begin
				cmd.wrap_calc = 1'b1;
				cmd.acc_clear = 1'b1;
				cnt_d         = '0;
				state_d       = S_TAP;
			end
			S_TAP: begin
				cmd.rd_en = 1'b1;
				if (!st.linear || cnt_q == 3'd3) begin
					state_d = S_DRAIN;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			S_DRAIN: begin
				state_d = S_PEND;
			end
			S_PEND: begin
				if (blend_q && !pass_q) begin
					cmd.save_r0 = 1'b1;
					cmd.lvl_inc = 1'b1;
					pass_d      = 1'b1;
					state_d     = S_OFS;
				end else begin
					state_d = S_FIN;
				end
			end
			S_FIN: begin
				if (!st.out_busy) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

[rtl/mbtf_dpath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mbtf_dpath
// Registers, log2 unit, address and weight logic, accumulators, texel store.
// ----------------------------------------------------------------------------
module mbtf_dpath import mbtf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data,
	input  wire logic [ADDR_W-1:0]  texel_address,
	input  wire logic [31:0]        texel_value,
	input  wire logic signed [23:0] u_coord,
	input  wire logic signed [23:0] v_coord,
	input  wire logic [15:0]        footprint,
	input  wire cmd_t               cmd,
	output status_t                 st,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [15:0]             channel_r,
	output logic [15:0]             channel_g,
	output logic [15:0]             channel_b,
	output logic [15:0]             channel_a
);

	function automatic logic [2*IDX_W-1:0] wrap_axis(input logic [15:0] i,
		input logic [DIM_W-1:0] dim, input logic clamp);
		logic [IDX_W-1:0] top, a, b;
		top = IDX_W'(dim - DIM_W'(1));
		if (clamp) begin
			if (i[15]) begin
				a = '0;
			end else if (i > 16'(top)) begin
				a = top;
			end else begin
				a = i[IDX_W-1:0];
			end
			b = (a == top) ? top : a + IDX_W'(1);
		end else begin
			a = i[15] ? top : i[IDX_W-1:0];
			b = (a == top) ? '0 : a + IDX_W'(1);
		end
		return {a, b};
	endfunction

	logic             fm_q, wu_q, wv_q;
	logic [DIM_W-1:0] bw_q, bh_q;
	logic [2:0]       lc_q, cc_q;
	logic [DIM_W-1:0] bwc, bhc;
	logic [LVL_W-1:0] levels;
	logic [2:0]       nc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fm_q <= 1'b1;
			wu_q <= 1'b0;
			wv_q <= 1'b0;
			bw_q <= DIM_W'(MAX_DIM);
			bh_q <= DIM_W'(MAX_DIM);
			lc_q <= 3'd1;
			cc_q <= 3'd4;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_FILTER_MODE:   fm_q <= cfg_data[0];
				REG_WRAP_U:        wu_q <= cfg_data[0];
				REG_WRAP_V:        wv_q <= cfg_data[0];
				REG_BASE_WIDTH:    bw_q <= cfg_data;
				REG_BASE_HEIGHT:   bh_q <= cfg_data;
				REG_LEVEL_COUNT:   lc_q <= cfg_data[2:0];
				REG_CHANNEL_COUNT: cc_q <= cfg_data[2:0];
				default: ;
			endcase
		end
	end

	assign bwc    = (bw_q == '0) ? DIM_W'(1) : (bw_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : bw_q;
	assign bhc    = (bh_q == '0) ? DIM_W'(1) : (bh_q > DIM_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : bh_q;
	assign levels = (lc_q == '0) ? LVL_W'(1) : LVL_W'(lc_q);
	assign nc     = (cc_q == '0) ? 3'd1 : (cc_q > 3'd4) ? 3'd4 : cc_q;

	logic [23:0] u_q, v_q;
	logic        fp_nz_q;
	logic [3:0]  e_q, e_in;
	logic [15:0] x_q;
	logic [7:0]  frac_q;
	logic [31:0] sq;
	logic [16:0] sq_t;
	logic [5:0]  ip;

	always_comb begin
		e_in = '0;
		for (int i = 0; i < 16; i++) begin
			if (footprint[i]) begin
				e_in = 4'(i);
			end
		end
	end

	assign sq   = 32'(x_q) * 32'(x_q);
	assign sq_t = sq[31:15];
	assign ip   = 6'(levels) + 6'(e_q) - 6'd17;

	always_ff @(posedge clk) begin
		if (cmd.start) begin
			u_q     <= u_coord;
			v_q     <= v_coord;
			fp_nz_q <= (footprint != '0);
			e_q     <= e_in;
			x_q     <= 16'(footprint << (4'd15 - e_in));
			frac_q  <= '0;
		end else if (cmd.log_step) begin
			if (sq_t[16]) begin
				x_q    <= sq_t[16:1];
				frac_q <= {frac_q[6:0], 1'b1};
			end else begin
				x_q    <= sq_t[15:0];
				frac_q <= {frac_q[6:0], 1'b0};
			end
		end
	end

	logic [LVL_W-1:0]  lvl_q, ofs_l_q;
	logic [ADDR_W-1:0] base_q;
	logic [DIM_W-1:0]  cw, ch;
	logic [2*DIM_W-1:0] ofs_area;

	assign cw       = lvl_dim(bwc, lvl_q);
	assign ch       = lvl_dim(bhc, lvl_q);
	assign ofs_area = (2*DIM_W)'(lvl_dim(bwc, ofs_l_q)) * (2*DIM_W)'(lvl_dim(bhc, ofs_l_q));

	always_ff @(posedge clk) begin
		if (cmd.lvl_zero) begin
			lvl_q <= '0;
		end else if (cmd.lvl_il) begin
			lvl_q <= LVL_W'(ip[2:0]);
		end else if (cmd.lvl_inc) begin
			lvl_q <= lvl_q + LVL_W'(1);
		end
		if (cmd.ofs_clear) begin
			ofs_l_q <= '0;
			base_q  <= '0;
		end else if (cmd.ofs_step) begin
			ofs_l_q <= ofs_l_q + LVL_W'(1);
			base_q  <= base_q + ADDR_W'(ofs_area);
		end
	end

	logic [31:0] pu_c, pu_r, pv_c, pv_r;
	logic [31:0] su_s1, sv_s1;

	assign pu_c = {{8{u_q[23]}}, u_q} * 32'(cw) - 32'd32768;
	assign pu_r = 32'(u_q[15:0]) * 32'(cw) - 32'd32768;
	assign pv_c = {{8{v_q[23]}}, v_q} * 32'(ch) - 32'd32768;
	assign pv_r = 32'(v_q[15:0]) * 32'(ch) - 32'd32768;

	always_ff @(posedge clk) begin
		if (cmd.pos_calc) begin
			su_s1 <= wu_q ? pu_c : pu_r;
			sv_s1 <= wv_q ? pv_c : pv_r;
		end
	end

	logic [IDX_W-1:0] x0_q, x1_q, y0_q, y1_q;
	logic [15:0]      fu_q, fv_q;

	always_ff @(posedge clk) begin
		if (cmd.wrap_calc) begin
			{x0_q, x1_q} <= wrap_axis(su_s1[31:16], cw, wu_q);
			{y0_q, y1_q} <= wrap_axis(sv_s1[31:16], ch, wv_q);
			fu_q         <= fm_q ? su_s1[15:0] : '0;
			fv_q         <= fm_q ? sv_s1[15:0] : '0;
		end
	end

	logic [IDX_W-1:0]  xs, ys;
	logic [ADDR_W-1:0] rd_addr, ram_addr;
	logic [16:0]       wa, wb;
	logic [33:0]       wt;
	logic [31:0]       rdata;

	assign xs       = cmd.tap[0] ? x1_q : x0_q;
	assign ys       = cmd.tap[1] ? y1_q : y0_q;
	assign rd_addr  = base_q + ADDR_W'(ADDR_W'(ys) * ADDR_W'(cw)) + ADDR_W'(xs);
	assign ram_addr = cmd.wr_en ? texel_address : rd_addr;
	assign wa       = cmd.tap[0] ? 17'(fu_q) : 17'h10000 - 17'(fu_q);
	assign wb       = cmd.tap[1] ? 17'(fv_q) : 17'h10000 - 17'(fv_q);
	assign wt       = 34'(wa) * 34'(wb);

	mbtf_ram #(
		.WIDTH(32),
		.DEPTH(STORE_DEPTH)
	) u_store (
		.clk  (clk),
		.we   (cmd.wr_en),
		.addr (ram_addr),
		.wdata(texel_value),
		.rdata(rdata)
	);

	logic        tv_s1;
	logic [33:0] wt_s1;
	logic [40:0] acc_q [4];
	logic [15:0] rnd [4];
	logic [15:0] r0_q [4];
	logic [15:0] fin [4];
	logic [24:0] mix [4];
	logic [15:0] out_q [4];
	logic        out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tv_s1 <= 1'b0;
		end else begin
			tv_s1 <= cmd.rd_en;
		end
	end

	always_ff @(posedge clk) begin
		wt_s1 <= wt;
		for (int c = 0; c < 4; c++) begin
			if (cmd.acc_clear) begin
				acc_q[c] <= '0;
			end else if (tv_s1) begin
				acc_q[c] <= acc_q[c] + 41'(wt_s1) * 41'(rdata[8*c +: 8]);
			end
			if (cmd.save_r0) begin
				r0_q[c] <= rnd[c];
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 4; c++) begin
			rnd[c] = 16'((acc_q[c] + 41'(1 << 23)) >> 24);
			mix[c] = 25'(r0_q[c]) * 25'(9'd256 - 9'(frac_q)) + 25'(rnd[c]) * 25'(frac_q)
				+ 25'd128;
			fin[c] = cmd.blend ? mix[c][23:8] : rnd[c];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			for (int c = 0; c < 4; c++) begin
				out_q[c] <= (3'(c) < nc) ? fin[c] : '0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign channel_r   = out_q[0];
	assign channel_g   = out_q[1];
	assign channel_b   = out_q[2];
	assign channel_a   = out_q[3];

	assign st.linear   = fm_q;
	assign st.multi    = (levels > LVL_W'(1));
	assign st.fp_nz    = fp_nz_q;
	assign st.blend_ok = !ip[5];
	assign st.ofs_done = (ofs_l_q == lvl_q);
	assign st.out_busy = out_valid_q && !out_ready;

endmodule
`default_nettype wire

[dv/mbtf_checker.sv]
// ----------------------------------------------------------------------------
// mbtf_checker
// Watches the config port and both word channels of the texture filter.
// Keeps its own texel store and register copy, predicts the filtered colour
// of every accepted sample word and compares each output word against it.
// ----------------------------------------------------------------------------
module mbtf_checker import mbtf_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [2:0]         cfg_index,
	input  wire logic [DIM_W-1:0]   cfg_data,
	input  wire logic               in_valid,
	input  wire logic               in_ready,
	input  wire logic               func,
	input  wire logic [ADDR_W-1:0]  texel_address,
	input  wire logic [31:0]        texel_value,
	input  wire logic signed [23:0] u_coord,
	input  wire logic signed [23:0] v_coord,
	input  wire logic [15:0]        footprint,
	input  wire logic               out_valid,
	input  wire logic               out_ready,
	input  wire logic [15:0]        channel_r,
	input  wire logic [15:0]        channel_g,
	input  wire logic [15:0]        channel_b,
	input  wire logic [15:0]        channel_a,
	output int                      fail_count,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic        filt, wrapu, wrapv;
	int          bw, bh, lc, cc;
	logic [31:0] texels [STORE_DEPTH];
	logic [63:0] colors_due [$];

	function automatic int clampi(int x, int lo, int hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic int dim_at(int base, int l);
		int d;
		d = clampi(base, 1, MAX_DIM) >> l;
		return d == 0 ? 1 : d;
	endfunction

	function automatic logic [31:0] fetch(int l, longint x, longint y);
		longint a;
		a = 0;
		for (int i = 0; i < l; i++)
			a += dim_at(bw, i) * dim_at(bh, i);
		a += y * dim_at(bw, l) + x;
		return texels[a % STORE_DEPTH];
	endfunction

	function automatic longint wrap_idx(longint i, longint d, logic clamp);
		longint r;
		if (clamp)
			return i < 0 ? 0 : (i > d - 1 ? d - 1 : i);
		r = i % d;
		return r < 0 ? r + d : r;
	endfunction

	function automatic longint texpos(logic signed [23:0] c, int d, output longint frac);
		longint s;
		s = longint'(c) * d - 32768;
		frac = s & 65535;
		return s >>> 16;
	endfunction

	function automatic logic [63:0] bilerp(int l, logic signed [23:0] u,
		logic signed [23:0] v, int nc);
		int          w, h;
		longint      fu, fv, x0, y0, x1, y1, acc;
		longint      wt [4];
		logic [31:0] tx [4];
		logic [63:0] res;
		w = dim_at(bw, l);
		h = dim_at(bh, l);
		x0 = wrap_idx(texpos(u, w, fu), w, wrapu);
		y0 = wrap_idx(texpos(v, h, fv), h, wrapv);
		x1 = wrap_idx(x0 + 1, w, wrapu);
		y1 = wrap_idx(y0 + 1, h, wrapv);
		wt[0] = (65536 - fu) * (65536 - fv);
		wt[1] = fu * (65536 - fv);
		wt[2] = (65536 - fu) * fv;
		wt[3] = fu * fv;
		tx[0] = fetch(l, x0, y0);
		tx[1] = fetch(l, x1, y0);
		tx[2] = fetch(l, x0, y1);
		tx[3] = fetch(l, x1, y1);
		res = '0;
		for (int c = 0; c < nc; c++) begin
			acc = 0;
			for (int k = 0; k < 4; k++)
				acc += wt[k] * longint'((tx[k] >> (8 * c)) & 32'hFF);
			res[16*c +: 16] = 16'((acc + (longint'(1) << 23)) >> 24);
		end
		return res;
	endfunction

	function automatic int log2q8(int fp);
		int     e, frac;
		longint x;
		e = 15;
		frac = 0;
		while (e > 0 && ((fp >> e) & 1) == 0)
			e--;
		x = longint'(fp << (15 - e));
		for (int i = 0; i < 8; i++) begin
			x = (x * x) >> 15;
			frac = frac << 1;
			if (x >= 65536) begin
				frac = frac | 1;
				x = x >> 1;
			end
		end
		return (e - 16) * 256 + frac;
	endfunction

	function automatic logic [63:0] filtered_color(logic signed [23:0] u,
		logic signed [23:0] v, logic [15:0] fp);
		int          nc, levels, top, lv, il, d;
		longint      fu;
		logic [31:0] t;
		logic [63:0] res, r1;
		nc = clampi(cc, 1, 4);
		levels = clampi(lc, 1, MAX_LEVELS);
		res = '0;
		if (!filt) begin
			t = fetch(0, wrap_idx(texpos(u, dim_at(bw, 0), fu), dim_at(bw, 0), wrapu),
				wrap_idx(texpos(v, dim_at(bh, 0), fu), dim_at(bh, 0), wrapv));
			for (int c = 0; c < nc; c++)
				res[16*c +: 16] = {t[8*c +: 8], 8'h00};
			return res;
		end
		top = (levels - 1) * 256;
		lv = (fp != 0) ? top + log2q8(int'(fp)) : -1;
		if (lv < 0 || levels == 1)
			return bilerp(0, u, v, nc);
		if (lv >= top) begin
			t = fetch(levels - 1, 0, 0);
			for (int c = 0; c < nc; c++)
				res[16*c +: 16] = {t[8*c +: 8], 8'h00};
			return res;
		end
		il = lv >> 8;
		d = lv & 255;
		res = bilerp(il, u, v, nc);
		r1 = bilerp(il + 1, u, v, nc);
		for (int c = 0; c < nc; c++)
			res[16*c +: 16] = 16'((int'(res[16*c +: 16]) * (256 - d)
				+ int'(r1[16*c +: 16]) * d + 128) >> 8);
		return res;
	endfunction

	task automatic report(string what, int got, int want);
		$display("mismatch %s: got %0h, want %0h at %0t", what, got, want, $realtime);
		fail_count++;
	endtask

	initial fail_count = 0;

	always @(posedge clk or negedge arst_n) begin
		logic [63:0] want;
		if (!arst_n) begin
			filt = 1'b1;
			wrapu = 1'b0;
			wrapv = 1'b0;
			bw = 64;
			bh = 64;
			lc = 1;
			cc = 4;
			colors_due.delete();
		end else begin
			if (cfg_we) begin
				case (reg_idx_t'(cfg_index))
					REG_FILTER_MODE:   filt = cfg_data[0];
					REG_WRAP_U:        wrapu = cfg_data[0];
					REG_WRAP_V:        wrapv = cfg_data[0];
					REG_BASE_WIDTH:    bw = int'(cfg_data);
					REG_BASE_HEIGHT:   bh = int'(cfg_data);
					REG_LEVEL_COUNT:   lc = int'(cfg_data[2:0]);
					REG_CHANNEL_COUNT: cc = int'(cfg_data[2:0]);
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				if (!func)
					texels[texel_address] = texel_value;
				else
					colors_due.push_back(filtered_color(u_coord, v_coord, footprint));
			end
			if (out_valid && out_ready) begin
				if (colors_due.size() == 0) begin
					report("unexpected word", int'(channel_r), 0);
				end else begin
					want = colors_due.pop_front();
					if (channel_r !== want[15:0])  report("red", channel_r, want[15:0]);
					if (channel_g !== want[31:16]) report("green", channel_g, want[31:16]);
					if (channel_b !== want[47:32]) report("blue", channel_b, want[47:32]);
					if (channel_a !== want[63:48]) report("alpha", channel_a, want[63:48]);
				end
			end
		end
		pending = colors_due.size();
	end

endmodule

[dv/mipmap_bilinear_texture_filter_top_test.sv]
// ----------------------------------------------------------------------------
// mipmap_bilinear_texture_filter_top_test
// Stimulus and verdict for the mipmap texture filter. Each phase programs
// the registers while idle, writes every pyramid texel not yet written, then
// sends directed (early phases) and random sample and write words, idling
// both channels at random but in phase 6. A checker predicts and compares colours.
// ----------------------------------------------------------------------------
module mipmap_bilinear_texture_filter_top_test;
	import mbtf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int IDLE_LIMIT = 3000;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [2:0]         cfg_index = '0;
	logic [DIM_W-1:0]   cfg_data = '0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic               func = 1'b0;
	logic [ADDR_W-1:0]  texel_address = '0;
	logic [31:0]        texel_value = '0;
	logic signed [23:0] u_coord = '0;
	logic signed [23:0] v_coord = '0;
	logic [15:0]        footprint = '0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [15:0]        channel_r, channel_g, channel_b, channel_a;
	int                 fail_count, pending;
	int                 idle_cycles = 0;
	logic               no_idle = 1'b0;
	bit                 filled [STORE_DEPTH];
	int                 cur_w = 64, cur_h = 64, cur_l = 1;

	always #5 clk = ~clk;

	mipmap_bilinear_texture_filter_top dut (.*);

	mbtf_checker u_checker (.*);

	always @(posedge clk)
		out_ready <= no_idle || ($urandom_range(0, 99) >= 14);

	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

	function automatic int clampi(int x, int lo, int hi);
		return x < lo ? lo : (x > hi ? hi : x);
	endfunction

	function automatic logic signed [23:0] rand_coord();
		if ($urandom_range(0, 1))
			return 24'($urandom());
		return 24'($urandom_range(0, 262143)) - 24'sd131072;
	endfunction

	function automatic logic [15:0] rand_footprint();
		case ($urandom_range(0, 3))
			0: return 16'($urandom());
			1: return 16'($urandom_range(1024, 65535));
			2: return 16'(1 << $urandom_range(0, 15)) | 16'($urandom_range(0, 255));
			default: return 16'($urandom_range(0, 3));
		endcase
	endfunction

	task automatic send(logic f, logic [ADDR_W-1:0] addr, logic [31:0] val,
		logic signed [23:0] u, logic signed [23:0] v, logic [15:0] fp);
		in_valid <= 1'b1;
		func <= f;
		texel_address <= addr;
		texel_value <= val;
		u_coord <= u;
		v_coord <= v;
		footprint <= fp;
		do @(posedge clk); while (!in_ready);
		if (!f)
			filled[addr] = 1'b1;
		if (!no_idle && $urandom_range(0, 99) < 14) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	task automatic store_texel(logic [ADDR_W-1:0] addr);
		send(1'b0, addr, $urandom(), rand_coord(), rand_coord(), 16'($urandom()));
	endtask

	task automatic sample(logic signed [23:0] u, logic signed [23:0] v, logic [15:0] fp);
		send(1'b1, '0, $urandom(), u, v, fp);
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (40) @(posedge clk);
	endtask

	task automatic cfg_write(reg_idx_t idx, int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= DIM_W'(val);
		@(posedge clk);
	endtask

	task automatic configure(int mode, int wu, int wv, int w, int h, int l, int c);
		cfg_write(REG_FILTER_MODE, mode);
		cfg_write(REG_WRAP_U, wu);
		cfg_write(REG_WRAP_V, wv);
		cfg_write(REG_BASE_WIDTH, w);
		cfg_write(REG_BASE_HEIGHT, h);
		cfg_write(REG_LEVEL_COUNT, l);
		cfg_write(REG_CHANNEL_COUNT, c);
		cfg_we <= 1'b0;
		cur_w = w & 127;
		cur_h = h & 127;
		cur_l = l & 7;
	endtask

	task automatic fill_pyramid();
		int total, dw, dh;
		total = 0;
		for (int l = 0; l < clampi(cur_l, 1, MAX_LEVELS); l++) begin
			dw = clampi(cur_w, 1, MAX_DIM) >> l;
			dh = clampi(cur_h, 1, MAX_DIM) >> l;
			total += (dw == 0 ? 1 : dw) * (dh == 0 ? 1 : dh);
		end
		for (int a = 0; a < total; a++)
			if (!filled[a % STORE_DEPTH])
				store_texel(ADDR_W'(a));
	endtask

	task automatic random_words(int n);
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 3) == 0)
				store_texel(ADDR_W'($urandom()));
			else
				sample(rand_coord(), rand_coord(), rand_footprint());
		end
	endtask

	task automatic corner_samples();
		sample(24'sh000000, 24'sh000000, 16'h0000);
		sample(24'sh7FFFFF, 24'sh7FFFFF, 16'hFFFF);
		sample(24'sh800000, 24'sh800000, 16'h0001);
		sample(24'sh010000, 24'sh008000, 16'h8000);
		sample(24'sh00FFFF, 24'shFF0001, 16'h0400);
		sample(24'shFFFFFF, 24'sh000001, 16'h0800);
		sample(24'sh004000, 24'sh00C000, 16'h2000);
		sample(24'sh7FFFFF, 24'sh800000, 16'h0100);
		sample(24'sh012345, 24'sh00ABCD, 16'h0003);
	endtask

	initial begin
		int mode;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		cfg_write(REG_BASE_WIDTH, 8);
		cfg_write(REG_BASE_HEIGHT, 8);
		cfg_we <= 1'b0;
		cur_w = 8;
		cur_h = 8;
		fill_pyramid();
		corner_samples();
		random_words(60);

		for (int p = 1; p <= 12; p++) begin
			settle();
			if (p == 1)
				cfg_write(REG_UNUSED, 127);
			case (p)
				1: configure(1, 0, 0, 16, 16, 7, 4);
				2: configure(0, 1, 1, 16, 16, 7, 1);
				3: configure(1, 1, 0, 1, 1, 0, 0);
				4: configure(1, 0, 1, 0, 127, 7, 7);
				5: configure(0, 0, 0, 1, 64, 3, 2);
				12: configure(1, 1, 1, 64, 1, 7, 3);
				default: begin
					mode = ($urandom_range(0, 3) != 0);
					configure(mode, $urandom_range(0, 1), $urandom_range(0, 1),
						$urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(1, 16),
						$urandom_range(0, 3) == 0 ? $urandom_range(0, 16) : $urandom_range(1, 16),
						$urandom_range(0, 7), $urandom_range(0, 7));
				end
			endcase
			no_idle = (p == 6);
			fill_pyramid();
			if (p <= 2)
				corner_samples();
			random_words(70);
		end
		no_idle = 1'b0;

		settle();
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
